@@ rtl/fcw_pkg.sv @@
`timescale 1ns / 1ps
package fcw_pkg;

  // Output and input number formats.
  localparam int ChannelBits  = 8;
  localparam int FlowFracBits = 12;
  localparam int FlowW        = 16;

  // Color wheel layout: segment lengths in wheel entries.
  localparam int WheelSize = 55;
  localparam int SegCount  = 6;
  localparam int LenRy     = 15;
  localparam int LenYg     = 6;
  localparam int LenGc     = 4;
  localparam int LenCb     = 11;
  localparam int LenBm     = 13;
  localparam int LenMr     = 6;

  // Fixed-point constants.
  localparam int Q16One      = 65536;
  localparam int PhaseW      = 16;
  localparam int HalfTurn    = 1 << (PhaseW - 1);
  localparam int ColW        = 17;
  localparam int CordicSteps = 14;
  localparam int CordicShift = 14;
  localparam int RadExtra    = 8;
  localparam int DesatShift  = FlowFracBits + RadExtra;
  localparam int ChanMax     = (1 << ChannelBits) - 1;

  // Datapath widths.
  localparam int XyW      = FlowW + CordicShift + 3;
  localparam int ZW       = PhaseW + 2;
  localparam int AngW     = 14;
  localparam int TurnIdxW = $clog2(CordicSteps);
  localparam int R2W      = 2 * FlowW;
  localparam int RadW     = R2W + 2 * RadExtra;
  localparam int RootW    = RadW / 2;
  localparam int RemW     = RootW + 2;
  localparam int NumCells = (RootW > CordicSteps) ? RootW : CordicSteps;
  localparam int StepW    = $clog2(NumCells);
  localparam int KW       = $clog2(WheelSize);
  localparam int PosW     = PhaseW + KW;

  // Squared radius limit of the unit circle.
  localparam logic [63:0] InsideLim = 64'd1 << (2 * FlowFracBits);

  // Channel behavior inside one wheel segment.
  localparam logic [1:0] ModeZero = 2'd0;
  localparam logic [1:0] ModeOne  = 2'd1;
  localparam logic [1:0] ModeRise = 2'd2;
  localparam logic [1:0] ModeFall = 2'd3;

  // CORDIC angles atan(2^-i) in units of 2^-16 turn.
  localparam logic [AngW-1:0] TurnTable [CordicSteps] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
    14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
  };

  // State handed from one chain cell to the next.
  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic                    base;
    logic                    in_circle;
    logic signed [XyW-1:0]   x;
    logic signed [XyW-1:0]   y;
    logic signed [ZW-1:0]    z;
    logic [RadW-1:0]         rad;
    logic [RemW-1:0]         rem;
    logic [RootW-1:0]        root;
  } cell_t;

  typedef logic [2:0][WheelSize-1:0][ColW-1:0] wheel_t;

  function automatic int seg_len(input int s);
    case (s)
      0:       return LenRy;
      1:       return LenYg;
      2:       return LenGc;
      3:       return LenCb;
      4:       return LenBm;
      default: return LenMr;
    endcase
  endfunction

  // Modes of red, green and blue within a segment.
  function automatic logic [1:0] seg_mode(input int s, input int ch);
    logic [5:0] modes;
    case (s)
      0:       modes = {ModeOne, ModeRise, ModeZero};
      1:       modes = {ModeFall, ModeOne, ModeZero};
      2:       modes = {ModeZero, ModeOne, ModeRise};
      3:       modes = {ModeZero, ModeFall, ModeOne};
      4:       modes = {ModeRise, ModeZero, ModeOne};
      default: modes = {ModeOne, ModeZero, ModeFall};
    endcase
    return modes[(2 - ch) * 2 +: 2];
  endfunction

  function automatic logic [ColW-1:0] wheel_entry(input int k, input int ch);
    int         s;
    int         off;
    int         ramp;
    logic [1:0] mode;
    logic [ColW-1:0] val;
    s   = 0;
    off = k;
    for (int i = 0; i < SegCount - 1; i++) begin
      if (s == i && off >= seg_len(i)) begin
        off = off - seg_len(i);
        s   = s + 1;
      end
    end
    case (s)
      0:       ramp = (Q16One * off) / LenRy;
      1:       ramp = (Q16One * off) / LenYg;
      2:       ramp = (Q16One * off) / LenGc;
      3:       ramp = (Q16One * off) / LenCb;
      4:       ramp = (Q16One * off) / LenBm;
      default: ramp = (Q16One * off) / LenMr;
    endcase
    mode = seg_mode(s, ch);
    case (mode)
      ModeOne:  val = ColW'(Q16One);
      ModeRise: val = ColW'(ramp);
      ModeFall: val = ColW'(Q16One - ramp);
      default:  val = '0;
    endcase
    return val;
  endfunction

  function automatic wheel_t build_wheel();
    wheel_t w;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < WheelSize; k++) begin
        w[ch][k] = wheel_entry(k, ch);
      end
    end
    return w;
  endfunction

  // Wheel colors in Q16, indexed by channel and entry.
  localparam wheel_t Wheel = build_wheel();

endpackage

@@ rtl/fcw_stream_if.sv @@
`timescale 1ns / 1ps
// Flow vector channel.
interface fcw_flow_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fcw_pkg::FlowW-1:0]     flow_x;
  logic signed [fcw_pkg::FlowW-1:0]     flow_y;

  modport source (output valid, output flow_x, output flow_y, input ready);
  modport sink (input valid, input flow_x, input flow_y, output ready);
endinterface

// Color channel.
interface fcw_color_if;
  logic                                 valid;
  logic                                 ready;
  logic [fcw_pkg::ChannelBits-1:0]      red;
  logic [fcw_pkg::ChannelBits-1:0]      green;
  logic [fcw_pkg::ChannelBits-1:0]      blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/fcw_prep.sv @@
`timescale 1ns / 1ps
module fcw_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  fcw_flow_if.sink       flow_i,
  output fcw_pkg::cell_t cell_o,
  input  logic           ready_i
);

  logic                              a_valid_q;
  logic                              a_zero_q;
  logic                              a_base_q;
  logic signed [fcw_pkg::FlowW:0]    a_x_q;
  logic signed [fcw_pkg::FlowW:0]    a_y_q;
  logic [fcw_pkg::R2W-1:0]           a_sqx_q;
  logic [fcw_pkg::R2W-1:0]           a_sqy_q;
  logic signed [fcw_pkg::FlowW:0]    x_ext;
  logic signed [fcw_pkg::FlowW:0]    y_ext;
  logic signed [fcw_pkg::R2W-1:0]    sqx;
  logic signed [fcw_pkg::R2W-1:0]    sqy;
  logic                              neg;
  logic [fcw_pkg::R2W-1:0]           r2;
  logic                              in_circle;
  logic                              a_ready;
  logic                              b_ready;
  fcw_pkg::cell_t                    cell_d;
  fcw_pkg::cell_t                    cell_q;

  // Each stage takes a beat when it is empty or its content moves on.
  assign b_ready      = !cell_q.valid || ready_i;
  assign a_ready      = !a_valid_q || b_ready;
  assign flow_i.ready = a_ready;
  assign cell_o       = cell_q;

  // Vectors in the left half plane are turned by half a turn.
  assign x_ext = (fcw_pkg::FlowW + 1)'(flow_i.flow_x);
  assign y_ext = (fcw_pkg::FlowW + 1)'(flow_i.flow_y);
  assign neg   = flow_i.flow_x[fcw_pkg::FlowW-1];
  assign sqx   = flow_i.flow_x * flow_i.flow_x;
  assign sqy   = flow_i.flow_y * flow_i.flow_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= flow_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_zero_q <= (flow_i.flow_x == '0) && (flow_i.flow_y == '0);
      a_base_q <= neg;
      a_x_q    <= neg ? -x_ext : x_ext;
      a_y_q    <= neg ? -y_ext : y_ext;
      a_sqx_q  <= sqx;
      a_sqy_q  <= sqy;
    end
  end

  // Squared radius, unit circle test and the first cell's state.
  always_comb begin
    r2               = a_sqx_q + a_sqy_q;
    in_circle        = 64'(r2) <= fcw_pkg::InsideLim;
    cell_d           = '0;
    cell_d.valid     = a_valid_q;
    cell_d.zero      = a_zero_q;
    cell_d.base      = a_base_q;
    cell_d.in_circle = in_circle;
    cell_d.x         = fcw_pkg::XyW'(a_x_q) <<< fcw_pkg::CordicShift;
    cell_d.y         = fcw_pkg::XyW'(a_y_q) <<< fcw_pkg::CordicShift;
    cell_d.rad       = in_circle ? (fcw_pkg::RadW'(r2) << (2 * fcw_pkg::RadExtra)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (b_ready) begin
      cell_q <= cell_d;
    end
  end

endmodule

@@ rtl/fcw_cell.sv @@
`timescale 1ns / 1ps
module fcw_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fcw_pkg::StepW-1:0]  step_i,
  input  fcw_pkg::cell_t             prev_i,
  output logic                       ready_o,
  output fcw_pkg::cell_t             next_o,
  input  logic                       ready_i
);

  fcw_pkg::cell_t                     cell_d;
  fcw_pkg::cell_t                     cell_q;
  logic signed [fcw_pkg::XyW-1:0]     dx;
  logic signed [fcw_pkg::XyW-1:0]     dy;
  logic [fcw_pkg::AngW-1:0]           ang;
  logic signed [fcw_pkg::ZW-1:0]      dz;
  logic [fcw_pkg::RemW+1:0]           rem_sh;
  logic [fcw_pkg::RemW+1:0]           trial;

  assign ready_o = !cell_q.valid || ready_i;
  assign next_o  = cell_q;

  always_comb begin
    cell_d = prev_i;

    // One vectoring CORDIC step: rotate toward the x axis, accumulate the angle.
    dx  = prev_i.y >>> step_i;
    dy  = prev_i.x >>> step_i;
    ang = (step_i < fcw_pkg::StepW'(fcw_pkg::CordicSteps)) ?
          fcw_pkg::TurnTable[step_i[fcw_pkg::TurnIdxW-1:0]] : '0;
    dz  = signed'(fcw_pkg::ZW'(ang));
    if (step_i < fcw_pkg::StepW'(fcw_pkg::CordicSteps)) begin
      if (!prev_i.y[fcw_pkg::XyW-1]) begin
        cell_d.x = prev_i.x + dx;
        cell_d.y = prev_i.y - dy;
        cell_d.z = prev_i.z + dz;
      end else begin
        cell_d.x = prev_i.x - dx;
        cell_d.y = prev_i.y + dy;
        cell_d.z = prev_i.z - dz;
      end
    end

    // One bit of the square root: bring down two radicand bits and try.
    rem_sh = {prev_i.rem, prev_i.rad[fcw_pkg::RadW-1 -: 2]};
    trial  = (fcw_pkg::RemW + 2)'({prev_i.root, 2'b01});
    if (step_i < fcw_pkg::StepW'(fcw_pkg::RootW)) begin
      cell_d.rad = prev_i.rad << 2;
      if (rem_sh >= trial) begin
        cell_d.rem  = fcw_pkg::RemW'(rem_sh - trial);
        cell_d.root = {prev_i.root[fcw_pkg::RootW-2:0], 1'b1};
      end else begin
        cell_d.rem  = rem_sh[fcw_pkg::RemW-1:0];
        cell_d.root = {prev_i.root[fcw_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (ready_o) begin
      cell_q <= cell_d;
    end
  end

endmodule

@@ rtl/fcw_color.sv @@
`timescale 1ns / 1ps
module fcw_color (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcw_pkg::cell_t cell_i,
  output logic           ready_o,
  fcw_color_if.source    color_o
);

  localparam int Stages = 7;
  localparam int ProdW  = 2 * fcw_pkg::ColW;
  localparam int DesW   = fcw_pkg::ColW + fcw_pkg::RootW;
  localparam int OutW   = fcw_pkg::ColW + fcw_pkg::ChannelBits;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] v_d;
  logic [Stages:0]   rdy;

  // Stage 0: phase and wheel position.
  logic signed [fcw_pkg::ZW-1:0]  turn;
  logic [fcw_pkg::PhaseW-1:0]     phase;
  logic [fcw_pkg::PosW-1:0]       pos;
  logic [fcw_pkg::KW-1:0]         k0_q;
  logic [fcw_pkg::PhaseW-1:0]     f0_q;
  logic                           in0_q;
  logic [fcw_pkg::RootW-1:0]      rq0_q;

  // Stage 1: wheel entries on both sides.
  logic [fcw_pkg::KW-1:0]               k1;
  logic [2:0][fcw_pkg::ColW-1:0]        c0_d;
  logic [2:0][fcw_pkg::ColW-1:0]        c1_d;
  logic [2:0][fcw_pkg::ColW-1:0]        c0_q;
  logic [2:0][fcw_pkg::ColW-1:0]        c1_q;
  logic [fcw_pkg::PhaseW-1:0]           f1_q;
  logic                                 in1_q;
  logic [fcw_pkg::RootW-1:0]            rq1_q;

  // Stage 2: blend products.
  logic [fcw_pkg::ColW-1:0]             nf;
  logic [2:0][ProdW-1:0]                pa_d;
  logic [2:0][ProdW-1:0]                pb_d;
  logic [2:0][ProdW-1:0]                pa_q;
  logic [2:0][ProdW-1:0]                pb_q;
  logic                                 in2_q;
  logic [fcw_pkg::RootW-1:0]            rq2_q;

  // Stage 3: blended color.
  logic [2:0][fcw_pkg::ColW-1:0]        col_d;
  logic [2:0][fcw_pkg::ColW-1:0]        col_q;
  logic                                 in3_q;
  logic [fcw_pkg::RootW-1:0]            rq3_q;

  // Stage 4: desaturation product and the dimmed color.
  logic [2:0][DesW-1:0]                 dp_d;
  logic [2:0][DesW-1:0]                 dp_q;
  logic [2:0][fcw_pkg::ColW-1:0]        q3_d;
  logic [2:0][fcw_pkg::ColW-1:0]        q3_q;
  logic                                 in4_q;

  // Stage 5 and 6: final color and channel scaling.
  logic [2:0][fcw_pkg::ColW-1:0]        cf_d;
  logic [2:0][fcw_pkg::ColW-1:0]        cf_q;
  logic [2:0][fcw_pkg::ChannelBits-1:0] ch_d;
  logic [2:0][fcw_pkg::ChannelBits-1:0] ch_q;

  // A stage takes a beat when empty or when its beat moves on.
  always_comb begin
    rdy[Stages] = color_o.ready;
    for (int s = Stages - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  assign ready_o = rdy[0];
  assign v_d     = {v_q[Stages-2:0], cell_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < Stages; s++) begin
        if (rdy[s]) begin
          v_q[s] <= v_d[s];
        end
      end
    end
  end

  // Phase in turns, then its place on the wheel.
  always_comb begin
    turn  = cell_i.z + (cell_i.base ? signed'(fcw_pkg::ZW'(fcw_pkg::HalfTurn)) : '0);
    phase = cell_i.zero ? '0 : turn[fcw_pkg::PhaseW-1:0];
    pos   = fcw_pkg::PosW'(phase) * fcw_pkg::PosW'(fcw_pkg::WheelSize - 1);
  end

  // Neighbor entry wraps at the end of the wheel.
  always_comb begin
    k1 = (k0_q == fcw_pkg::KW'(fcw_pkg::WheelSize - 1)) ? '0 : k0_q + 1'b1;
    nf = fcw_pkg::ColW'(fcw_pkg::Q16One) - fcw_pkg::ColW'(f1_q);
    for (int ch = 0; ch < 3; ch++) begin
      c0_d[ch]  = fcw_pkg::Wheel[ch][k0_q];
      c1_d[ch]  = fcw_pkg::Wheel[ch][k1];
      pa_d[ch]  = ProdW'(nf) * ProdW'(c0_q[ch]);
      pb_d[ch]  = ProdW'(f1_q) * ProdW'(c1_q[ch]);
      col_d[ch] = fcw_pkg::ColW'(((ProdW + 1)'(pa_q[ch]) + (ProdW + 1)'(pb_q[ch])) >> 16);
      dp_d[ch]  = DesW'(fcw_pkg::ColW'(fcw_pkg::Q16One) - col_q[ch]) * DesW'(rq3_q);
      q3_d[ch]  = fcw_pkg::ColW'(((fcw_pkg::ColW + 2)'(col_q[ch]) *
                                  (fcw_pkg::ColW + 2)'(3)) >> 2);
      cf_d[ch]  = in4_q ? fcw_pkg::ColW'(fcw_pkg::Q16One) -
                          fcw_pkg::ColW'(dp_q[ch] >> fcw_pkg::DesatShift) : q3_q[ch];
      ch_d[ch]  = fcw_pkg::ChannelBits'((OutW'(cf_q[ch]) *
                                         OutW'(fcw_pkg::ChanMax)) >> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      k0_q  <= pos[fcw_pkg::PosW-1:fcw_pkg::PhaseW];
      f0_q  <= pos[fcw_pkg::PhaseW-1:0];
      in0_q <= cell_i.in_circle;
      rq0_q <= cell_i.root;
    end
    if (rdy[1]) begin
      c0_q  <= c0_d;
      c1_q  <= c1_d;
      f1_q  <= f0_q;
      in1_q <= in0_q;
      rq1_q <= rq0_q;
    end
    if (rdy[2]) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      in2_q <= in1_q;
      rq2_q <= rq1_q;
    end
    if (rdy[3]) begin
      col_q <= col_d;
      in3_q <= in2_q;
      rq3_q <= rq2_q;
    end
    if (rdy[4]) begin
      dp_q  <= dp_d;
      q3_q  <= q3_d;
      in4_q <= in3_q;
    end
    if (rdy[5]) begin
      cf_q <= cf_d;
    end
    if (rdy[6]) begin
      ch_q <= ch_d;
    end
  end

  assign color_o.valid = v_q[Stages-1];
  assign color_o.red   = ch_q[0];
  assign color_o.green = ch_q[1];
  assign color_o.blue  = ch_q[2];

endmodule

@@ rtl/flow_to_color_wheel.sv @@
// Flow vector to color wheel: one RGB color per flow vector.
// Stages from an accepted input beat to its output beat:
//   2 input stages, 24 chain cells (one square root bit per cell, 14 also CORDIC), 7 color stages.
// Throughput: one beat per cycle; a stalled output fills the stages one by one before input stops.
// Reset: asynchronous, active low; clears every stage's valid flag and the whole cell state along the chain.
`timescale 1ns / 1ps
module flow_to_color_wheel (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcw_flow_if.sink    flow_i,
  fcw_color_if.source color_o
);

  fcw_pkg::cell_t                chain [fcw_pkg::NumCells+1];
  logic [fcw_pkg::NumCells:0]    cell_ready;

  // Sign fold, squares and radius test.
  fcw_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flow_i  (flow_i),
    .cell_o  (chain[0]),
    .ready_i (cell_ready[0])
  );

  // Row of cells: angle and radius root, one step each.
  for (genvar k = 0; k < fcw_pkg::NumCells; k++) begin : g_cell
    fcw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (fcw_pkg::StepW'(k)),
      .prev_i  (chain[k]),
      .ready_o (cell_ready[k]),
      .next_o  (chain[k+1]),
      .ready_i (cell_ready[k+1])
    );
  end

  // Wheel lookup, blend, saturation and channel scaling.
  fcw_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (chain[fcw_pkg::NumCells]),
    .ready_o (cell_ready[fcw_pkg::NumCells]),
    .color_o (color_o)
  );

`ifndef SYNTH
  // The rotated vector never leaves the right half plane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[fcw_pkg::NumCells].valid |-> !chain[fcw_pkg::NumCells].x[fcw_pkg::XyW-1])
    else $error("rotated x went negative");

  // Inside the unit circle the radius root is at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[fcw_pkg::NumCells].valid && chain[fcw_pkg::NumCells].in_circle |->
      64'(chain[fcw_pkg::NumCells].root) <= (64'd1 << fcw_pkg::DesatShift))
    else $error("radius root exceeds one inside the unit circle");

  // A beat at the chain end that the color stages refuse stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[fcw_pkg::NumCells].valid && !cell_ready[fcw_pkg::NumCells] |=>
      chain[fcw_pkg::NumCells].valid && $stable(chain[fcw_pkg::NumCells].root)
      && $stable(chain[fcw_pkg::NumCells].z))
    else $error("chain end beat lost while stalled");
`endif

endmodule

@@ verif/fcw_color_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels of the flow-to-color block, predicts the color of every
// accepted flow beat and compares each color beat with the oldest prediction.
module fcw_color_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  fcw_flow_if   flow_i,
  fcw_color_if  color_i,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct {
    logic [fcw_pkg::ChannelBits-1:0] red;
    logic [fcw_pkg::ChannelBits-1:0] green;
    logic [fcw_pkg::ChannelBits-1:0] blue;
  } rgb_t;

  // Wheel segment lengths and the behavior of red, green and blue in each segment.
  localparam int SegLens [fcw_pkg::SegCount] = '{
    fcw_pkg::LenRy, fcw_pkg::LenYg, fcw_pkg::LenGc,
    fcw_pkg::LenCb, fcw_pkg::LenBm, fcw_pkg::LenMr
  };
  localparam logic [1:0] ChanModes [fcw_pkg::SegCount][3] = '{
    '{fcw_pkg::ModeOne,  fcw_pkg::ModeRise, fcw_pkg::ModeZero},
    '{fcw_pkg::ModeFall, fcw_pkg::ModeOne,  fcw_pkg::ModeZero},
    '{fcw_pkg::ModeZero, fcw_pkg::ModeOne,  fcw_pkg::ModeRise},
    '{fcw_pkg::ModeZero, fcw_pkg::ModeFall, fcw_pkg::ModeOne},
    '{fcw_pkg::ModeRise, fcw_pkg::ModeZero, fcw_pkg::ModeOne},
    '{fcw_pkg::ModeOne,  fcw_pkg::ModeZero, fcw_pkg::ModeFall}
  };

  rgb_t expected_colors [$];
  int   mismatches;

  // Q16 level of one channel at one wheel entry.
  function automatic longint wheel_level(input int k, input int ch);
    int     seg;
    int     off;
    longint ramp;
    seg = 0;
    off = k % fcw_pkg::WheelSize;
    while (seg < fcw_pkg::SegCount - 1 && off >= SegLens[seg]) begin
      off = off - SegLens[seg];
      seg = seg + 1;
    end
    ramp = (longint'(fcw_pkg::Q16One) * off) / SegLens[seg];
    case (ChanModes[seg][ch])
      fcw_pkg::ModeOne:  return fcw_pkg::Q16One;
      fcw_pkg::ModeRise: return ramp;
      fcw_pkg::ModeFall: return fcw_pkg::Q16One - ramp;
      default:           return 0;
    endcase
  endfunction

  // Bitwise integer square root, rounded down.
  function automatic longint unsigned square_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Expected color for one flow vector.
  function automatic rgb_t predict_color(input logic signed [fcw_pkg::FlowW-1:0] fx,
                                         input logic signed [fcw_pkg::FlowW-1:0] fy);
    longint          x;
    longint          y;
    longint          z;
    longint          base;
    longint          dx;
    longint          dy;
    longint          col;
    longint          c0;
    longint          c1;
    longint unsigned r2;
    longint unsigned rq;
    int unsigned     phase;
    int unsigned     pos;
    int unsigned     k0;
    int unsigned     k1;
    int unsigned     f;
    logic            in_circle;
    logic [fcw_pkg::ChannelBits-1:0] chan [3];
    rgb_t            res;
    x  = fx;
    y  = fy;
    r2 = longint'(x * x) + longint'(y * y);

    // Phase by vectoring CORDIC on the right half plane.
    if (x == 0 && y == 0) begin
      phase = 0;
    end else begin
      base = 0;
      z    = 0;
      if (x < 0) begin
        x    = -x;
        y    = -y;
        base = fcw_pkg::HalfTurn;
      end
      x = x <<< fcw_pkg::CordicShift;
      y = y <<< fcw_pkg::CordicShift;
      for (int i = 0; i < fcw_pkg::CordicSteps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(fcw_pkg::TurnTable[i]);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(fcw_pkg::TurnTable[i]);
        end
      end
      phase = int'((base + z) & 64'hFFFF);
    end

    // Wheel position and blend weight.
    pos = phase * (fcw_pkg::WheelSize - 1);
    k0  = pos >> 16;
    k1  = (k0 + 1) % fcw_pkg::WheelSize;
    f   = pos & 32'hFFFF;

    // Radius: desaturate inside the unit circle, darken outside.
    in_circle = (r2 <= (64'd1 << (2 * fcw_pkg::FlowFracBits)));
    rq        = in_circle ? square_root(r2 << (2 * fcw_pkg::RadExtra)) : 0;

    for (int ch = 0; ch < 3; ch++) begin
      c0  = wheel_level(k0, ch);
      c1  = wheel_level(k1, ch);
      col = ((longint'(fcw_pkg::Q16One) - f) * c0 + longint'(f) * c1) >> 16;
      if (in_circle) begin
        col = fcw_pkg::Q16One - (((fcw_pkg::Q16One - col) * longint'(rq)) >>
                                 (fcw_pkg::FlowFracBits + fcw_pkg::RadExtra));
      end else begin
        col = (col * 3) >> 2;
      end
      chan[ch] = fcw_pkg::ChannelBits'((col * fcw_pkg::ChanMax) >> 16);
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    return res;
  endfunction

  initial begin
    mismatches   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Compare the color beat first, then queue the prediction for a new flow beat.
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (color_i.valid && color_i.ready) begin
        if (expected_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: color beat %0d/%0d/%0d arrived with none expected",
                     $realtime, color_i.red, color_i.green, color_i.blue);
          end
        end else begin
          want = expected_colors.pop_front();
          if (want.red !== color_i.red || want.green !== color_i.green ||
              want.blue !== color_i.blue) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       color_i.red, color_i.green, color_i.blue);
            end
          end
        end
      end
      if (flow_i.valid && flow_i.ready) begin
        expected_colors.push_back(predict_color(flow_i.flow_x, flow_i.flow_y));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_colors.size();
  end

endmodule

@@ verif/tb_flow_to_color_wheel.sv @@
`timescale 1ns / 1ps
// Drives flow vectors in bursts, stalls the color side and reports the verdict.
module tb_flow_to_color_wheel;

  localparam int RandomItems = 1600;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;

  fcw_flow_if  flow_if ();
  fcw_color_if color_if ();

  flow_to_color_wheel uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flow_i (flow_if),
    .color_o(color_if)
  );

  fcw_color_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flow_i      (flow_if),
    .color_i     (color_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Color side stalls: one of four styles, drawn anew at random throughout the run.
  int stall_style;
  int stall_count;
  initial begin
    stall_style = 0;
    stall_count = 0;
  end
  always @(negedge clk_i) begin
    stall_count <= stall_count + 1;
    if (stall_count % 200 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0:       color_if.ready <= 1'b1;
      1:       color_if.ready <= ($urandom_range(0, 3) != 0);
      2:       color_if.ready <= ($urandom_range(0, 3) == 0);
      default: color_if.ready <= ((stall_count % 7) < 3);
    endcase
  end

  // One flow beat, held until accepted.
  task automatic send_flow(input logic signed [fcw_pkg::FlowW-1:0] x,
                           input logic signed [fcw_pkg::FlowW-1:0] y);
    @(negedge clk_i);
    flow_if.valid  <= 1'b1;
    flow_if.flow_x <= x;
    flow_if.flow_y <= y;
    @(posedge clk_i);
    while (!flow_if.ready) @(posedge clk_i);
  endtask

  // Idle cycles with junk on the data lines.
  task automatic idle_flow(input int n);
    repeat (n) begin
      @(negedge clk_i);
      flow_if.valid  <= 1'b0;
      flow_if.flow_x <= fcw_pkg::FlowW'($urandom);
      flow_if.flow_y <= fcw_pkg::FlowW'($urandom);
    end
  endtask

  // Hold off until every predicted color has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [fcw_pkg::FlowW-1:0] rand_span(input int lim);
    int v;
    v = int'($urandom_range(0, 2 * lim)) - lim;
    return fcw_pkg::FlowW'(v);
  endfunction

  // Random vector: mostly inside or near the unit circle, some anywhere.
  task automatic pick_vector(output logic signed [fcw_pkg::FlowW-1:0] x,
                             output logic signed [fcw_pkg::FlowW-1:0] y);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = rand_span(2896);
        y = rand_span(2896);
      end
      4, 5: begin
        x = rand_span(4096);
        y = rand_span(4096);
      end
      6: begin
        x = rand_span(8192);
        y = rand_span(8192);
      end
      7, 8: begin
        x = fcw_pkg::FlowW'($urandom);
        y = fcw_pkg::FlowW'($urandom);
      end
      default: begin
        // Near the unit circle or on an axis.
        if ($urandom_range(0, 1)) begin
          x = fcw_pkg::FlowW'(($urandom_range(0, 1) ? 4096 : -4096) + rand_span(3));
          y = rand_span(40);
        end else begin
          x = fcw_pkg::FlowW'($urandom);
          y = '0;
        end
        if ($urandom_range(0, 1)) begin
          {x, y} = {y, x};
        end
      end
    endcase
  endtask

  logic signed [fcw_pkg::FlowW-1:0] directed_x [$] = '{
    0, 4096, 0, -4096, 0, 100, 32767, 1, -1, 0, 0, -1,
    -32768, 32767, -32768, 32767, -32768, 0, 2896, 2897, 4095, -4096, 4096
  };
  logic signed [fcw_pkg::FlowW-1:0] directed_y [$] = '{
    0, 0, 4096, 0, -4096, 0, 0, 0, 0, 1, -1, -1,
    -32768, 32767, 32767, -32768, 0, -32768, 2896, 2897, 1, 1, -1
  };

  initial begin
    logic signed [fcw_pkg::FlowW-1:0] x;
    logic signed [fcw_pkg::FlowW-1:0] y;
    int burst_left;
    flow_if.valid  = 1'b0;
    flow_if.flow_x = '0;
    flow_if.flow_y = '0;
    color_if.ready = 1'b0;
    rst_ni         = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed vectors: zero, unit radius on each axis, extremes, circle edge.
    foreach (directed_x[i]) send_flow(directed_x[i], directed_y[i]);
    idle_flow(1);
    wait_drained();

    // Random vectors in bursts.
    burst_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        idle_flow(1);
        wait_drained();
      end
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_flow($urandom_range(1, 8));
        burst_left = $urandom_range(1, 60);
      end
      pick_vector(x, y);
      send_flow(x, y);
      burst_left--;
    end
    idle_flow(1);

    // Wait for the last colors, then a little longer for stray beats.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
